// ----- sv/rclt_pkg.sv -----
// Shared types and constants for the random cycle link table.
// Holds request and status codes, controller states and the control/status
// structs that join the controller and the datapath. No dependencies.
package rclt_pkg;

  localparam int LINE_W    = 10;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;
  localparam int STEP_W    = 32;
  localparam int SLOT_W    = 11;
  localparam int GEN_W     = 64;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 1'd1;

  localparam logic [SLOT_W-1:0] SLOT_RESET = 11'd1024;
  localparam logic [GEN_W-1:0]  SEED_RESET = 64'h9e37_79b9_7f4a_7c15;

  localparam logic [REQ_W-1:0] REQ_BUILD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CHASE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_SH_INIT,
    S_SH_MOD,
    S_SH_WAIT,
    S_SH_RD,
    S_SH_WA,
    S_SH_WB,
    S_LK_INIT,
    S_LK_RD,
    S_LK_WR,
    S_LK_LAST,
    S_RD_ISSUE,
    S_RD_DATA,
    S_CH_MOD,
    S_CH_WAIT,
    S_CH_STEP,
    S_CH_WALK
  } state_t;

  typedef enum logic [1:0] {
    LA_LINE,
    LA_P,
    LA_Q
  } link_addr_t;

  typedef enum logic [1:0] {
    RS_ZERO,
    RS_LINK,
    RS_P
  } resp_sel_t;

  typedef enum logic {
    MS_SWAP,
    MS_CHASE
  } mod_src_t;

  typedef enum logic [1:0] {
    OW_NONE,
    OW_FILL,
    OW_HI,
    OW_LO
  } ord_wr_t;

  typedef struct packed {
    logic              capture;
    logic              build_init;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              cnt_clr;
    logic              cnt_top;
    logic              mod_start;
    mod_src_t          mod_src;
    logic              ord_rd;
    ord_wr_t           ord_wr;
    logic              lk_take;
    logic              lk_close;
    logic              chase_load;
    logic              link_rd;
    link_addr_t        link_sel;
    logic              k_dec;
    logic              resp;
    resp_sel_t         resp_sel;
    logic [STAT_W-1:0] resp_status;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             built;
    logic             in_range;
    logic             cnt_last;
    logic             cnt_one;
    logic             n_one;
    logic             mod_done;
    logic             k_zero;
  } sts_t;

endpackage

// ----- sv/rclt_mod.sv -----
// Bit-serial remainder unit: one dividend bit per cycle, a run covers all 64 dividend bits.
// Depends on rclt_pkg for the dividend width.
module rclt_mod import rclt_pkg::*; #(
  parameter int DIV_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [GEN_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] rem
);

  localparam int CNT_W = $clog2(GEN_W);

  logic [GEN_W-1:0] sh_r;
  logic [DIV_W-1:0] div_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] rem_nxt;
  logic [DIV_W:0]   trial;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  always_comb begin
    trial = {rem_r, sh_r[GEN_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = DIV_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = DIV_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(GEN_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      sh_r  <= {sh_r[GEN_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- sv/rclt_ctrl.sv -----
// Request sequencer: walks build, read and chase requests step by step.
// Depends on rclt_pkg for states and the command/status structs.
module rclt_ctrl import rclt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.req == REQ_BUILD) begin
          cmd.build_init = 1'b1;
          state_nxt      = S_FILL;
        end else if (sts.req == REQ_READ || sts.req == REQ_CHASE) begin
          if (!sts.built) begin
            cmd.resp        = 1'b1;
            cmd.resp_sel    = RS_ZERO;
            cmd.resp_status = ST_NOT_BUILT;
            state_nxt       = S_IDLE;
          end else if (!sts.in_range) begin
            cmd.resp        = 1'b1;
            cmd.resp_sel    = RS_ZERO;
            cmd.resp_status = ST_RANGE;
            state_nxt       = S_IDLE;
          end else if (sts.req == REQ_READ) begin
            state_nxt = S_RD_ISSUE;
          end else begin
            state_nxt = S_CH_MOD;
          end
        end else begin
          cmd.resp        = 1'b1;
          cmd.resp_sel    = RS_ZERO;
          cmd.resp_status = ST_OK;
          state_nxt       = S_IDLE;
        end
      end
      S_FILL: begin
        cmd.ord_wr = OW_FILL;
        if (sts.cnt_last) begin
          state_nxt = S_SH_INIT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_SH_INIT: begin
        cmd.cnt_top = 1'b1;
        state_nxt   = sts.n_one ? S_LK_INIT : S_SH_MOD;
      end
      S_SH_MOD: begin
        cmd.mod_start = 1'b1;
        cmd.mod_src   = MS_SWAP;
        state_nxt     = S_SH_WAIT;
      end
      S_SH_WAIT: begin
        if (sts.mod_done) begin
          state_nxt = S_SH_RD;
        end
      end
      S_SH_RD: begin
        cmd.ord_rd = 1'b1;
        state_nxt  = S_SH_WA;
      end
      S_SH_WA: begin
        cmd.ord_wr = OW_HI;
        state_nxt  = S_SH_WB;
      end
      S_SH_WB: begin
        cmd.ord_wr = OW_LO;
        if (sts.cnt_one) begin
          state_nxt = S_LK_INIT;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_SH_MOD;
        end
      end
      S_LK_INIT: begin
        cmd.cnt_clr = 1'b1;
        state_nxt   = S_LK_RD;
      end
      S_LK_RD: begin
        cmd.ord_rd = 1'b1;
        state_nxt  = S_LK_WR;
      end
      S_LK_WR: begin
        cmd.lk_take = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_LK_LAST;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_LK_RD;
        end
      end
      S_LK_LAST: begin
        cmd.lk_close    = 1'b1;
        cmd.resp        = 1'b1;
        cmd.resp_sel    = RS_ZERO;
        cmd.resp_status = ST_OK;
        state_nxt       = S_IDLE;
      end
      S_RD_ISSUE: begin
        cmd.link_rd  = 1'b1;
        cmd.link_sel = LA_LINE;
        state_nxt    = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd.resp        = 1'b1;
        cmd.resp_sel    = RS_LINK;
        cmd.resp_status = ST_OK;
        state_nxt       = S_IDLE;
      end
      S_CH_MOD: begin
        cmd.mod_start = 1'b1;
        cmd.mod_src   = MS_CHASE;
        state_nxt     = S_CH_WAIT;
      end
      S_CH_WAIT: begin
        if (sts.mod_done) begin
          cmd.chase_load = 1'b1;
          state_nxt      = S_CH_STEP;
        end
      end
      S_CH_STEP: begin
        if (sts.k_zero) begin
          cmd.resp        = 1'b1;
          cmd.resp_sel    = RS_P;
          cmd.resp_status = ST_OK;
          state_nxt       = S_IDLE;
        end else begin
          cmd.link_rd  = 1'b1;
          cmd.link_sel = LA_P;
          cmd.k_dec    = 1'b1;
          state_nxt    = S_CH_WALK;
        end
      end
      S_CH_WALK: begin
        if (sts.k_zero) begin
          cmd.resp        = 1'b1;
          cmd.resp_sel    = RS_LINK;
          cmd.resp_status = ST_OK;
          state_nxt       = S_IDLE;
        end else begin
          cmd.link_rd  = 1'b1;
          cmd.link_sel = LA_Q;
          cmd.k_dec    = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- sv/rclt_dp.sv -----
// Datapath: order and link memories, xorshift64 generator, counters,
// remainder unit and the result register. Depends on rclt_pkg and rclt_mod.
module rclt_dp import rclt_pkg::*; #(
  parameter int MAX_LINES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [LINE_W-1:0] in_line_index,
  input  logic [STEP_W-1:0] in_step_count,
  input  logic [SLOT_W-1:0] slot_count,
  input  logic [GEN_W-1:0]  seed,
  output logic              out_valid,
  output logic [LINE_W-1:0] out_result_line,
  output logic [STAT_W-1:0] out_status
);

  localparam int AW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);

  function automatic logic [GEN_W-1:0] xorshift64(input logic [GEN_W-1:0] x);
    logic [GEN_W-1:0] v;
    v = x ^ (x << 13);
    v = v ^ (v >> 7);
    v = v ^ (v << 17);
    return v;
  endfunction

  logic [AW-1:0] order_mem [MAX_LINES];
  logic [AW-1:0] link_mem  [MAX_LINES];

  logic [REQ_W-1:0]  req_r;
  logic [LINE_W-1:0] line_r;
  logic [STEP_W-1:0] steps_r;
  logic              built_r;
  logic [CW-1:0]     built_n_r;
  logic [CW-1:0]     n_r;
  logic [CW-1:0]     eff_n;
  logic [AW-1:0]     cnt_r;
  logic [GEN_W-1:0]  gen_r;
  logic [GEN_W-1:0]  gen_nxt;
  logic [AW-1:0]     first_r;
  logic [AW-1:0]     prev_r;
  logic [AW-1:0]     p_r;
  logic [AW-1:0]     k_r;
  logic [AW-1:0]     ord_qa;
  logic [AW-1:0]     ord_qb;
  logic [AW-1:0]     link_q;
  logic              out_valid_r;
  logic [LINE_W-1:0] out_line_r;
  logic [STAT_W-1:0] out_status_r;

  logic              ord_we;
  logic [AW-1:0]     ord_waddr;
  logic [AW-1:0]     ord_wdata;
  logic              link_we;
  logic [AW-1:0]     link_wdata;
  logic [AW-1:0]     link_raddr;
  logic [GEN_W-1:0]  mod_dividend;
  logic [CW-1:0]     mod_divisor;
  logic              mod_done;
  logic [CW-1:0]     mod_rem;
  logic [AW-1:0]     rem_a;

  assign gen_nxt = xorshift64(gen_r);
  assign rem_a   = AW'(mod_rem);

  always_comb begin
    if (slot_count == '0) begin
      eff_n = CW'(1);
    end else if (32'(slot_count) > 32'(MAX_LINES)) begin
      eff_n = CW'(MAX_LINES);
    end else begin
      eff_n = CW'(slot_count);
    end
  end

  always_comb begin
    if (cmd.mod_src == MS_CHASE) begin
      mod_dividend = GEN_W'(steps_r);
      mod_divisor  = built_n_r;
    end else begin
      mod_dividend = gen_nxt;
      mod_divisor  = CW'(cnt_r);
    end
  end

  rclt_mod #(
    .DIV_W (CW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = cnt_r;
    ord_wdata = cnt_r;
    case (cmd.ord_wr)
      OW_FILL: begin
        ord_we = 1'b1;
      end
      OW_HI: begin
        ord_we    = 1'b1;
        ord_wdata = ord_qb;
      end
      OW_LO: begin
        ord_we    = 1'b1;
        ord_waddr = rem_a;
        ord_wdata = ord_qa;
      end
      default: begin
        ord_we = 1'b0;
      end
    endcase
  end

  assign link_we    = cmd.lk_close || (cmd.lk_take && (cnt_r != '0));
  assign link_wdata = cmd.lk_close ? first_r : ord_qa;

  always_comb begin
    case (cmd.link_sel)
      LA_LINE: link_raddr = AW'(line_r);
      LA_Q:    link_raddr = link_q;
      default: link_raddr = p_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      order_mem[ord_waddr] <= ord_wdata;
    end
    if (cmd.ord_rd) begin
      ord_qa <= order_mem[cnt_r];
      ord_qb <= order_mem[rem_a];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[prev_r] <= link_wdata;
    end
    if (cmd.link_rd) begin
      link_q <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.resp;
      if (cmd.lk_close) begin
        built_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_req_type;
      line_r  <= in_line_index;
      steps_r <= in_step_count;
    end
    if (cmd.build_init) begin
      gen_r <= seed;
      n_r   <= eff_n;
    end else if (cmd.mod_start && cmd.mod_src == MS_SWAP) begin
      gen_r <= gen_nxt;
    end
    if (cmd.build_init || cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_top) begin
      cnt_r <= AW'(n_r - CW'(1));
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + AW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_r <= cnt_r - AW'(1);
    end
    if (cmd.lk_take) begin
      prev_r <= ord_qa;
      if (cnt_r == '0) begin
        first_r <= ord_qa;
      end
    end
    if (cmd.lk_close) begin
      built_n_r <= n_r;
    end
    if (cmd.chase_load) begin
      k_r <= rem_a;
      p_r <= AW'(line_r);
    end else if (cmd.k_dec) begin
      k_r <= k_r - AW'(1);
    end
    if (cmd.resp) begin
      out_status_r <= cmd.resp_status;
      case (cmd.resp_sel)
        RS_LINK: out_line_r <= LINE_W'(link_q);
        RS_P:    out_line_r <= LINE_W'(p_r);
        default: out_line_r <= '0;
      endcase
    end
  end

  always_comb begin
    sts.req      = req_r;
    sts.built    = built_r;
    sts.in_range = (32'(line_r) < 32'(built_n_r));
    sts.cnt_last = (CW'(cnt_r) == (n_r - CW'(1)));
    sts.cnt_one  = (cnt_r == AW'(1));
    sts.n_one    = (n_r == CW'(1));
    sts.mod_done = mod_done;
    sts.k_zero   = (k_r == '0);
  end

  assign out_valid       = out_valid_r;
  assign out_result_line = out_line_r;
  assign out_status      = out_status_r;

endmodule

// ----- sv/random_cycle_link_table_top.sv -----
// Top level of the random cycle link table: configuration registers,
// sequencer and datapath. Depends on rclt_pkg, rclt_ctrl and rclt_dp.
//
// One request at a time: a request is taken when start is high and busy is
// low, and exactly one result beat follows on out_valid for a single cycle;
// the receiver cannot stall it. A read does decode and one link-table read,
// then the registered result beat. A chase reduces step_count mod n in the
// bit-serial remainder unit, then does one link-table read per step. A build
// of n lines fills the order memory, swaps each position from n - 1 down to 1
// (a new xorshift64 value reduced by the same remainder unit, then a two-port
// read and two writes of the order memory), then writes the links. Configuration
// writes are to be made only while busy is low and out_valid has fired for the
// last request; the block itself does not enforce this.
module random_cycle_link_table_top import rclt_pkg::*; #(
  parameter int MAX_LINES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [LINE_W-1:0]    in_line_index,
  input  logic [STEP_W-1:0]    in_step_count,
  output logic                 out_valid,
  output logic [LINE_W-1:0]    out_result_line,
  output logic [STAT_W-1:0]    out_status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GEN_W-1:0]     cfg_wdata
);

  logic [SLOT_W-1:0] slot_count_r;
  logic [GEN_W-1:0]  seed_r;
  cmd_t              cmd;
  sts_t              sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= SLOT_RESET;
      seed_r       <= SEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOT_COUNT: slot_count_r <= cfg_wdata[SLOT_W-1:0];
        CFG_SEED:       seed_r       <= cfg_wdata;
        default:        seed_r       <= seed_r;
      endcase
    end
  end

  rclt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  rclt_dp #(
    .MAX_LINES (MAX_LINES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_req_type),
    .in_line_index   (in_line_index),
    .in_step_count   (in_step_count),
    .slot_count      (slot_count_r),
    .seed            (seed_r),
    .out_valid       (out_valid),
    .out_result_line (out_result_line),
    .out_status      (out_status)
  );

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for random_cycle_link_table_top: builds, link reads, chases, unused request codes.
// Keeps its own shuffle/link predictor and checks every result beat in order.
// Depends on rclt_pkg and the top level only.
`timescale 1ns / 1ps

module tb import rclt_pkg::*;;

  localparam int          TB_MAX_LINES    = 1024;
  localparam int          CYCLE_LIMIT     = 4_000_000;
  localparam int          TAIL_CYCLES     = 200;
  localparam int          PHASES          = 12;
  localparam int          ITEMS_PER_PHASE = 125;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [STAT_W-1:0] status;
  } answer_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [REQ_W-1:0]     in_req_type;
  logic [LINE_W-1:0]    in_line_index;
  logic [STEP_W-1:0]    in_step_count;
  logic                 out_valid;
  logic [LINE_W-1:0]    out_result_line;
  logic [STAT_W-1:0]    out_status;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GEN_W-1:0]     cfg_wdata;

  random_cycle_link_table_top #(.MAX_LINES(TB_MAX_LINES)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_line_index   (in_line_index),
    .in_step_count   (in_step_count),
    .out_valid       (out_valid),
    .out_result_line (out_result_line),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [LINE_W-1:0] m_order [0:TB_MAX_LINES-1];
  logic [LINE_W-1:0] m_link  [0:TB_MAX_LINES-1];
  logic [GEN_W-1:0]  m_gen;
  logic              m_built;
  int unsigned       m_lines;
  logic [SLOT_W-1:0] m_slot;
  logic [GEN_W-1:0]  m_seed;

  answer_t answers_due [$];
  answer_t got_ans;
  answer_t due_ans;

  int unsigned mismatches = 0;
  int unsigned n_sent     = 0;
  int unsigned n_checked  = 0;
  int unsigned n_builds   = 0;
  int unsigned n_chases   = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned burst_left = 0;
  bit          no_gaps    = 1'b0;

  function automatic logic [GEN_W-1:0] xs_next(input logic [GEN_W-1:0] x);
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    return x;
  endfunction

  task automatic shuffle_build();
    int unsigned       n;
    int unsigned       i;
    int unsigned       j;
    int unsigned       nx;
    logic [LINE_W-1:0] t;
    n = (m_slot == 0) ? 1 : ((m_slot > TB_MAX_LINES) ? TB_MAX_LINES : m_slot);
    m_gen = m_seed;
    for (i = 0; i < n; i++) m_order[i] = LINE_W'(i);
    for (i = n - 1; i > 0; i--) begin
      m_gen = xs_next(m_gen);
      j = 32'(m_gen % 64'(i));
      t = m_order[i];
      m_order[i] = m_order[j];
      m_order[j] = t;
    end
    for (i = 0; i < n; i++) begin
      nx = (i + 1 == n) ? 0 : i + 1;
      m_link[m_order[i]] = m_order[nx];
    end
    m_lines = n;
    m_built = 1'b1;
  endtask

  task automatic predict_answer(input logic [REQ_W-1:0] req, input logic [LINE_W-1:0] idx,
                                input logic [STEP_W-1:0] steps, output answer_t ans);
    int unsigned       k;
    logic [LINE_W-1:0] p;
    ans.line   = '0;
    ans.status = ST_OK;
    if (req == REQ_BUILD) begin
      shuffle_build();
      n_builds++;
    end else if (req == REQ_READ || req == REQ_CHASE) begin
      if (!m_built) begin
        ans.status = ST_NOT_BUILT;
      end else if (32'(idx) >= m_lines) begin
        ans.status = ST_RANGE;
      end else if (req == REQ_READ) begin
        ans.line = m_link[idx];
      end else begin
        k = steps % m_lines;
        p = idx;
        while (k > 0) begin
          p = m_link[p];
          k--;
        end
        ans.line = p;
        n_chases++;
      end
    end
  endtask

  task automatic pause_burst();
    int unsigned gap;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 10);
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_req(input logic [REQ_W-1:0] req, input logic [LINE_W-1:0] idx,
                          input logic [STEP_W-1:0] steps);
    answer_t ans;
    pause_burst();
    @(negedge clk);
    start         <= 1'b1;
    in_req_type   <= req;
    in_line_index <= idx;
    in_step_count <= steps;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_answer(req, idx, steps, ans);
    answers_due.push_back(ans);
    n_sent++;
    @(negedge clk);
    start         <= 1'b0;
    in_req_type   <= REQ_W'($urandom);
    in_line_index <= LINE_W'($urandom);
    in_step_count <= $urandom;
  endtask

  task automatic wait_idle();
    while (answers_due.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GEN_W-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_index <= CFG_IDX_W'($urandom);
    cfg_wdata <= {$urandom, $urandom};
    if (idx == CFG_SLOT_COUNT) m_slot = val[SLOT_W-1:0];
    else m_seed = val;
  endtask

  // slot count word with junk above the 11 used bits
  function automatic logic [GEN_W-1:0] slot_word(input logic [SLOT_W-1:0] slot);
    logic [GEN_W-1:0] v;
    v = {$urandom, $urandom};
    v[SLOT_W-1:0] = slot;
    return v;
  endfunction

  task automatic test_before_build();
    send_req(REQ_READ, 10'd0, 32'd0);
    send_req(REQ_CHASE, 10'd1023, '1);
    send_req(REQ_UNUSED, LINE_W'($urandom), $urandom);
    send_req(REQ_READ, 10'd1023, $urandom);
  endtask

  task automatic test_reset_build();
    send_req(REQ_BUILD, '1, '1);
    send_req(REQ_READ, 10'd0, 32'd0);
    send_req(REQ_READ, 10'd1023, '1);
    send_req(REQ_CHASE, 10'd1023, 32'd0);
    send_req(REQ_CHASE, 10'd512, '1);
    send_req(REQ_CHASE, 10'd0, 32'd1024);
  endtask

  task automatic test_single_line();
    write_reg(CFG_SLOT_COUNT, slot_word(11'd0));
    write_reg(CFG_SEED, {$urandom, $urandom});
    send_req(REQ_BUILD, '0, '0);
    send_req(REQ_READ, 10'd0, $urandom);
    send_req(REQ_READ, 10'd1, 32'd0);
    send_req(REQ_CHASE, 10'd0, '1);
    send_req(REQ_CHASE, 10'd1023, 32'd5);
  endtask

  task automatic test_two_lines();
    write_reg(CFG_SLOT_COUNT, slot_word(11'd2));
    send_req(REQ_BUILD, LINE_W'($urandom), $urandom);
    send_req(REQ_READ, 10'd0, 32'd0);
    send_req(REQ_READ, 10'd1, 32'd0);
    send_req(REQ_READ, 10'd2, 32'd0);
  endtask

  task automatic test_clamp_zero_seed();
    write_reg(CFG_SLOT_COUNT, slot_word(11'd2047));
    write_reg(CFG_SEED, 64'd0);
    send_req(REQ_BUILD, '0, '0);
    send_req(REQ_READ, 10'd1023, 32'd0);
    send_req(REQ_CHASE, 10'd7, 32'd100);
  endtask

  task automatic test_latched_count();
    write_reg(CFG_SLOT_COUNT, slot_word(11'd3));
    send_req(REQ_READ, 10'd1000, 32'd0);
    send_req(REQ_CHASE, 10'd900, 32'd7);
    write_reg(CFG_SEED, '1);
    send_req(REQ_BUILD, '1, '0);
    send_req(REQ_READ, 10'd3, 32'd0);
    send_req(REQ_CHASE, 10'd2, '1);
  endtask

  task automatic test_random_mix();
    int unsigned       p;
    int unsigned       k;
    int unsigned       r;
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  seed_val;
    logic [REQ_W-1:0]  req;
    logic [LINE_W-1:0] idx;
    logic [STEP_W-1:0] steps;
    for (p = 0; p < PHASES; p++) begin
      case (p % 6)
        2: slot = $urandom_range(0, 1) ? 11'd0 : 11'd1;
        3: slot = 11'd2;
        4: slot = SLOT_W'($urandom_range(49, 200));
        default: slot = SLOT_W'($urandom_range(3, 48));
      endcase
      if (p == 2) seed_val = '0;
      else if (p == 3) seed_val = '1;
      else seed_val = {$urandom, $urandom};
      write_reg(CFG_SLOT_COUNT, slot_word(slot));
      write_reg(CFG_SEED, seed_val);
      no_gaps = (p % 4 == 1);
      send_req(REQ_BUILD, LINE_W'($urandom), $urandom);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        // new count or seed must not touch the current table
        if (k == ITEMS_PER_PHASE / 2 && $urandom_range(0, 1)) begin
          write_reg(CFG_SLOT_COUNT, slot_word(SLOT_W'($urandom_range(1, 48))));
          if ($urandom_range(0, 1)) write_reg(CFG_SEED, {$urandom, $urandom});
        end
        r = $urandom_range(0, 99);
        if (r < 3) req = REQ_BUILD;
        else if (r < 6) req = REQ_UNUSED;
        else if (r < 45) req = REQ_READ;
        else req = REQ_CHASE;
        if ($urandom_range(0, 99) < 85) idx = LINE_W'($urandom_range(0, m_lines - 1));
        else idx = LINE_W'($urandom);
        case ($urandom_range(0, 4))
          0: steps = $urandom;
          1: steps = $urandom_range(0, 2 * m_lines);
          2: steps = '0;
          3: steps = '1;
          default: steps = m_lines * $urandom_range(1, 4000) + $urandom_range(0, 1);
        endcase
        send_req(req, idx, steps);
      end
    end
    no_gaps = 1'b0;
  endtask

  // result beat checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_ans.line   = out_result_line;
      got_ans.status = out_status;
      if (answers_due.size() == 0) begin
        if (mismatches < 10)
          $display("tb: unexpected beat: line %0d status %0d", got_ans.line, got_ans.status);
        mismatches++;
      end else begin
        due_ans = answers_due.pop_front();
        n_checked++;
        if (got_ans !== due_ans) begin
          if (mismatches < 10)
            $display("tb: mismatch on beat %0d: expected line %0d status %0d, got line %0d status %0d",
                     n_checked, due_ans.line, due_ans.status, got_ans.line, got_ans.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: timeout after %0d cycles", cycle_cnt);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_req_type   = '0;
    in_line_index = '0;
    in_step_count = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    m_built       = 1'b0;
    m_lines       = 0;
    m_slot        = SLOT_RESET;
    m_seed        = SEED_RESET;
    m_gen         = SEED_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_before_build();
    test_reset_build();
    test_single_line();
    test_two_lines();
    test_clamp_zero_seed();
    test_latched_count();
    test_random_mix();

    while (answers_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d requests, %0d builds, %0d chases, %0d random config phases",
             n_sent, n_builds, n_chases, PHASES);
    $display("tb: %0d result beats checked, %0d mismatches, %0d cycles",
             n_checked, mismatches, cycle_cnt);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
